### rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared types, codes and sizes of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int OCC_W  = 5;

    typedef enum logic [1:0] {
        OP_ENQ  = 2'd0,
        OP_DEQ  = 2'd1,
        OP_MOD  = 2'd2,
        OP_PEEK = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ENQ_RD,
        S_ENQ_WR,
        S_HEAD_RD,
        S_HEAD_CAP,
        S_REM_RD,
        S_REM_WR,
        S_FIND_RD,
        S_FIND_CHK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] prio;
    } entry_t;

    typedef struct packed {
        op_t                      operation;
        logic signed [DATA_W-1:0] item_value;
        logic signed [DATA_W-1:0] item_priority;
    } cmd_t;

    typedef struct packed {
        status_t                  status;
        logic signed [DATA_W-1:0] head_value;
        logic signed [DATA_W-1:0] head_priority;
        logic [OCC_W-1:0]         occupancy;
    } res_t;

    typedef struct packed {
        logic less;
        logic equal;
    } cmp_t;

endpackage

### rtl/spq_if.sv
// ----------------------------------------------------------------------------
// Sorted priority queue channels
// Valid/ready channels for operation requests and their results.
// ----------------------------------------------------------------------------
interface spq_req_if;
    logic                             valid;
    logic                             ready;
    spq_pkg::op_t                     operation;
    logic signed [spq_pkg::DATA_W-1:0] item_value;
    logic signed [spq_pkg::DATA_W-1:0] item_priority;

    modport source (output valid, output operation, output item_value,
                    output item_priority, input ready);
    modport sink   (input valid, input operation, input item_value,
                    input item_priority, output ready);
endinterface

interface spq_rsp_if;
    logic                              valid;
    logic                              ready;
    spq_pkg::status_t                  status;
    logic signed [spq_pkg::DATA_W-1:0] head_value;
    logic signed [spq_pkg::DATA_W-1:0] head_priority;
    logic [spq_pkg::OCC_W-1:0]         occupancy;

    modport source (output valid, output status, output head_value,
                    output head_priority, output occupancy, input ready);
    modport sink   (input valid, input status, input head_value,
                    input head_priority, input occupancy, output ready);
endinterface

### rtl/spq_cmp.sv
// ----------------------------------------------------------------------------
// Sorted priority queue compare unit
// Signed priority compare and data match shared by the insert and search steps.
// ----------------------------------------------------------------------------
module spq_cmp
(
    input  spq_pkg::entry_t slot,
    input  spq_pkg::entry_t key,
    output spq_pkg::cmp_t   result
);

    assign result.less  = (slot.prio < key.prio);
    assign result.equal = (slot.value == key.value);

endmodule

### rtl/spq_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted priority queue sequencer
// Entry memory and the step sequencer that searches, shifts and inserts.
// ----------------------------------------------------------------------------
module spq_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    input  spq_pkg::cmd_t   cmd,
    output logic            cmd_ready,
    output logic            res_valid,
    output spq_pkg::res_t   res,
    input  logic            res_ready
);

    spq_pkg::entry_t mem [spq_pkg::DEPTH];
    spq_pkg::entry_t rdata_reg;

    spq_pkg::state_t  state_reg, state_next;
    spq_pkg::op_t     op_reg, op_next;
    spq_pkg::entry_t  key_reg, key_next;
    spq_pkg::entry_t  head_reg, head_next;
    spq_pkg::status_t status_reg, status_next;
    logic [spq_pkg::CNT_W-1:0] ptr_reg, ptr_next;
    logic [spq_pkg::CNT_W-1:0] count_reg, count_next;
    logic [spq_pkg::CNT_W-1:0] ptr_inc, ptr_dec, count_dec;

    logic                      mem_we;
    logic [spq_pkg::IDX_W-1:0] mem_waddr;
    logic [spq_pkg::IDX_W-1:0] mem_raddr;
    spq_pkg::entry_t           mem_wdata;
    spq_pkg::cmp_t             cmp;

    spq_cmp u_cmp
    (
        .slot   (rdata_reg),
        .key    (key_reg),
        .result (cmp)
    );

    assign ptr_inc   = ptr_reg + spq_pkg::CNT_W'(1);
    assign ptr_dec   = ptr_reg - spq_pkg::CNT_W'(1);
    assign count_dec = count_reg - spq_pkg::CNT_W'(1);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spq_pkg::S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        head_reg   <= head_next;
        status_reg <= status_next;
        ptr_reg    <= ptr_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        head_next   = head_reg;
        status_next = status_reg;
        ptr_next    = ptr_reg;
        count_next  = count_reg;
        mem_we      = 1'b0;
        mem_waddr   = ptr_reg[spq_pkg::IDX_W-1:0];
        mem_wdata   = key_reg;
        mem_raddr   = ptr_reg[spq_pkg::IDX_W-1:0];
        cmd_ready   = 1'b0;
        res_valid   = 1'b0;

        unique case (state_reg)
            spq_pkg::S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    op_next     = cmd.operation;
                    key_next    = '{value: cmd.item_value, prio: cmd.item_priority};
                    head_next   = '0;
                    status_next = spq_pkg::ST_OK;
                    unique case (cmd.operation)
                        spq_pkg::OP_ENQ:
                        begin
                            if (count_reg == spq_pkg::CNT_W'(spq_pkg::DEPTH))
                            begin
                                status_next = spq_pkg::ST_FULL;
                                state_next  = spq_pkg::S_DONE;
                            end
                            else
                            begin
                                ptr_next   = count_reg;
                                state_next = spq_pkg::S_ENQ_RD;
                            end
                        end
                        spq_pkg::OP_DEQ, spq_pkg::OP_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = spq_pkg::ST_EMPTY;
                                state_next  = spq_pkg::S_DONE;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                state_next = spq_pkg::S_HEAD_RD;
                            end
                        end
                        spq_pkg::OP_MOD:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = spq_pkg::ST_EMPTY;
                                state_next  = spq_pkg::S_DONE;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                state_next = spq_pkg::S_FIND_RD;
                            end
                        end
                    endcase
                end
            end
            spq_pkg::S_ENQ_RD:
            begin
                if (ptr_reg == '0)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = key_reg;
                    count_next = count_reg + spq_pkg::CNT_W'(1);
                    state_next = spq_pkg::S_DONE;
                end
                else
                begin
                    mem_raddr  = ptr_dec[spq_pkg::IDX_W-1:0];
                    state_next = spq_pkg::S_ENQ_WR;
                end
            end
            spq_pkg::S_ENQ_WR:
            begin
                mem_we = 1'b1;
                if (cmp.less)
                begin
                    mem_wdata  = rdata_reg;
                    ptr_next   = ptr_dec;
                    state_next = spq_pkg::S_ENQ_RD;
                end
                else
                begin
                    mem_wdata  = key_reg;
                    count_next = count_reg + spq_pkg::CNT_W'(1);
                    state_next = spq_pkg::S_DONE;
                end
            end
            spq_pkg::S_HEAD_RD:
            begin
                mem_raddr  = '0;
                state_next = spq_pkg::S_HEAD_CAP;
            end
            spq_pkg::S_HEAD_CAP:
            begin
                head_next = rdata_reg;
                if (op_reg == spq_pkg::OP_PEEK)
                begin
                    state_next = spq_pkg::S_DONE;
                end
                else
                begin
                    state_next = spq_pkg::S_REM_RD;
                end
            end
            spq_pkg::S_REM_RD:
            begin
                if (ptr_inc < count_reg)
                begin
                    mem_raddr  = ptr_inc[spq_pkg::IDX_W-1:0];
                    state_next = spq_pkg::S_REM_WR;
                end
                else
                begin
                    count_next = count_dec;
                    if (op_reg == spq_pkg::OP_MOD)
                    begin
                        ptr_next   = count_dec;
                        state_next = spq_pkg::S_ENQ_RD;
                    end
                    else
                    begin
                        state_next = spq_pkg::S_DONE;
                    end
                end
            end
            spq_pkg::S_REM_WR:
            begin
                mem_we     = 1'b1;
                mem_wdata  = rdata_reg;
                ptr_next   = ptr_inc;
                state_next = spq_pkg::S_REM_RD;
            end
            spq_pkg::S_FIND_RD:
            begin
                if (ptr_reg == count_reg)
                begin
                    status_next = spq_pkg::ST_NOT_FOUND;
                    state_next  = spq_pkg::S_DONE;
                end
                else
                begin
                    state_next = spq_pkg::S_FIND_CHK;
                end
            end
            spq_pkg::S_FIND_CHK:
            begin
                if (cmp.equal)
                begin
                    state_next = spq_pkg::S_REM_RD;
                end
                else
                begin
                    ptr_next   = ptr_inc;
                    state_next = spq_pkg::S_FIND_RD;
                end
            end
            spq_pkg::S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = spq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = spq_pkg::S_IDLE;
            end
        endcase
    end

    assign res.status        = status_reg;
    assign res.head_value    = head_reg.value;
    assign res.head_priority = head_reg.prio;
    assign res.occupancy     = spq_pkg::OCC_W'(count_reg);

endmodule

### rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// Sorted priority queue
// Priority queue held in descending priority order in a single-port entry
// memory, worked through by a step sequencer with one shared compare unit.
// ----------------------------------------------------------------------------
//  Channel   Role    Payload
//  req       sink    operation, item_value, item_priority
//  rsp       source  status, head_value, head_priority, occupancy
//
//  Enqueue walks from the tail, shifting each lower-priority entry down, then
//  writes the new one; dequeue reads the head and moves every other entry up;
//  peek only reads the head; a full or empty reject goes straight to the result.
//  Modify searches the entries one by one, then removes and reinserts the entry.
//  Reset clears only the sequencer and the entry count; no clearing pass.
//  A result waits in the output register while the next transfer is taken.
// ----------------------------------------------------------------------------
module sorted_priority_queue
(
    input  logic  clk,
    input  logic  rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);

    spq_pkg::cmd_t cmd;
    spq_pkg::res_t res;
    spq_pkg::res_t out_reg;
    logic          out_valid_reg;
    logic          res_valid;
    logic          res_ready;

    assign cmd.operation     = req.operation;
    assign cmd.item_value    = req.item_value;
    assign cmd.item_priority = req.item_priority;

    spq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (req.valid),
        .cmd       (cmd),
        .cmd_ready (req.ready),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    assign res_ready = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_reg.status;
    assign rsp.head_value    = out_reg.head_value;
    assign rsp.head_priority = out_reg.head_priority;
    assign rsp.occupancy     = out_reg.occupancy;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request accepted while the previous one is still in work");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == spq_pkg::ST_FULL
            |-> rsp.occupancy == spq_pkg::OCC_W'(spq_pkg::DEPTH))
        else $error("full status reported below capacity");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == spq_pkg::ST_EMPTY |-> rsp.occupancy == '0)
        else $error("empty status reported with entries held");

    a_error_head_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != spq_pkg::ST_OK
            |-> rsp.head_value == '0 && rsp.head_priority == '0)
        else $error("head fields set on an error result");
`endif

endmodule

### dv/spq_order_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue order checker
// Watches the request and result channels, keeps its own copy of the queue
// contents and checks every result against the outcome that the accepted
// operation should give.
// ----------------------------------------------------------------------------
module spq_order_checker
    import spq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    spq_req_if   req,
    spq_rsp_if   rsp,
    output int   fail_count,
    output int   outstanding,
    output int   results_checked,
    output int   full_hits,
    output int   empty_hits,
    output int   missing_hits
);

    logic signed [DATA_W-1:0] held_value [DEPTH];
    logic signed [DATA_W-1:0] held_prio  [DEPTH];
    int                       held_count = 0;
    res_t                     awaited_results [$];

    initial
    begin
        fail_count      = 0;
        outstanding     = 0;
        results_checked = 0;
        full_hits       = 0;
        empty_hits      = 0;
        missing_hits    = 0;
    end

    function automatic void insert_held(logic signed [DATA_W-1:0] value,
                                        logic signed [DATA_W-1:0] prio);
        int pos;
        pos = 0;
        while (pos < held_count && !(held_prio[pos] < prio))
            pos++;
        for (int i = held_count; i > pos; i--)
        begin
            held_value[i] = held_value[i - 1];
            held_prio[i]  = held_prio[i - 1];
        end
        held_value[pos] = value;
        held_prio[pos]  = prio;
        held_count++;
    endfunction

    function automatic void remove_held(int pos);
        for (int i = pos; i + 1 < held_count; i++)
        begin
            held_value[i] = held_value[i + 1];
            held_prio[i]  = held_prio[i + 1];
        end
        held_count--;
    endfunction

    function automatic res_t apply_queue_op(cmd_t c);
        res_t r;
        int   pos;
        r        = '0;
        r.status = ST_OK;
        case (c.operation)
            OP_ENQ:
            begin
                if (held_count >= DEPTH)
                    r.status = ST_FULL;
                else
                    insert_held(c.item_value, c.item_priority);
            end
            OP_DEQ, OP_PEEK:
            begin
                if (held_count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.head_value    = held_value[0];
                    r.head_priority = held_prio[0];
                    if (c.operation == OP_DEQ)
                        remove_held(0);
                end
            end
            default:
            begin
                if (held_count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    pos = 0;
                    while (pos < held_count && held_value[pos] != c.item_value)
                        pos++;
                    if (pos >= held_count)
                        r.status = ST_NOT_FOUND;
                    else
                    begin
                        remove_held(pos);
                        insert_held(c.item_value, c.item_priority);
                    end
                end
            end
        endcase
        r.occupancy = OCC_W'(held_count);
        return r;
    endfunction

    task automatic check_field(string field, logic [DATA_W-1:0] want,
                               logic [DATA_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %h, actual %h",
                     $time, field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        cmd_t cmd_in;
        res_t want;
        if (rst_n)
        begin
            if (req.valid && req.ready)
            begin
                cmd_in.operation     = req.operation;
                cmd_in.item_value    = req.item_value;
                cmd_in.item_priority = req.item_priority;
                awaited_results.push_back(apply_queue_op(cmd_in));
            end
            if (rsp.valid && rsp.ready)
            begin
                results_checked++;
                case (rsp.status)
                    ST_FULL:      full_hits++;
                    ST_EMPTY:     empty_hits++;
                    ST_NOT_FOUND: missing_hits++;
                    default:      ;
                endcase
                if (awaited_results.size() == 0)
                begin
                    $display("%0t ns: result transfer with nothing expected, actual status %0d",
                             $time, rsp.status);
                    fail_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("status", DATA_W'(want.status), DATA_W'(rsp.status));
                    check_field("head_value", want.head_value, rsp.head_value);
                    check_field("head_priority", want.head_priority, rsp.head_priority);
                    check_field("occupancy", DATA_W'(want.occupancy),
                                DATA_W'(rsp.occupancy));
                end
            end
            outstanding = awaited_results.size();
        end
    end

endmodule

### dv/tb_sorted_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Drives directed corner cases and then bursts of random operations that fill,
// drain and reorder the queue, with random sender gaps and receiver stalls.
// The order checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue;
    import spq_pkg::*;

    logic clk = 1'b0;
    logic rst_n;

    spq_req_if req_ch ();
    spq_rsp_if rsp_ch ();

    int fail_count;
    int outstanding;
    int results_checked;
    int full_hits;
    int empty_hits;
    int missing_hits;

    int unsigned       op_sent [4];
    logic [DATA_W-1:0] known_values [$];
    int unsigned       ready_mode  = 0;
    int unsigned       ready_phase = 0;

    always #6 clk = ~clk;

    sorted_priority_queue dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    spq_order_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (req_ch),
        .rsp             (rsp_ch),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .full_hits       (full_hits),
        .empty_hits      (empty_hits),
        .missing_hits    (missing_hits)
    );

    always @(negedge clk)
    begin
        if (ready_phase == 0)
        begin
            ready_mode  = $urandom_range(0, 3);
            ready_phase = $urandom_range(16, 96);
        end
        ready_phase--;
        case (ready_mode)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= ($urandom_range(0, 9) < 7);
            2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ch.ready <= ((ready_phase % 8) < 3);
        endcase
    end

    task automatic send_op(op_t op, logic [DATA_W-1:0] value, logic [DATA_W-1:0] prio);
        req_ch.valid         <= 1'b1;
        req_ch.operation     <= op;
        req_ch.item_value    <= value;
        req_ch.item_priority <= prio;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
        op_sent[op]++;
        if (op == OP_ENQ)
        begin
            known_values.push_back(value);
            if (known_values.size() > 24)
                void'(known_values.pop_front());
        end
    endtask

    task automatic pause_sender(int unsigned cycles);
        if (cycles > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (cycles) @(negedge clk);
        end
    endtask

    task automatic drain_sender();
        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2, 3:    return $urandom;
            default: return 32'($urandom_range(0, 12)) - 32'd6;
        endcase
    endfunction

    function automatic op_t choose_op(int unsigned mix);
        int unsigned roll;
        int unsigned enq_w;
        int unsigned deq_w;
        roll = $urandom_range(0, 99);
        case (mix)
            0:
            begin
                enq_w = 60;
                deq_w = 15;
            end
            1:
            begin
                enq_w = 15;
                deq_w = 60;
            end
            default:
            begin
                enq_w = 30;
                deq_w = 30;
            end
        endcase
        if (roll < enq_w)
            return OP_ENQ;
        if (roll < enq_w + deq_w)
            return OP_DEQ;
        if (roll < enq_w + deq_w + 15)
            return OP_MOD;
        return OP_PEEK;
    endfunction

    initial
    begin
        int unsigned       burst_len;
        int unsigned       burst_idx;
        int unsigned       random_sent;
        op_t               op;
        logic [DATA_W-1:0] value;

        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.operation     = OP_ENQ;
        req_ch.item_value    = '0;
        req_ch.item_priority = '0;
        rsp_ch.ready         = 1'b0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_op(OP_PEEK, 32'h0, 32'h0);
        send_op(OP_DEQ, 32'h7fff_ffff, 32'h0);
        send_op(OP_MOD, 32'h1, 32'h1);
        send_op(OP_ENQ, 32'h8000_0000, 32'h8000_0000);
        send_op(OP_ENQ, 32'h7fff_ffff, 32'h7fff_ffff);
        send_op(OP_PEEK, 32'h0, 32'h0);
        send_op(OP_ENQ, 32'hffff_ffff, 32'hffff_ffff);
        send_op(OP_ENQ, 32'h0, 32'h0);
        send_op(OP_ENQ, 32'h11, 32'd5);
        send_op(OP_ENQ, 32'h22, 32'd5);
        send_op(OP_ENQ, 32'h11, 32'h8000_0000);
        send_op(OP_MOD, 32'h11, 32'h7fff_ffff);
        send_op(OP_MOD, 32'h5a5a_5a5a, 32'd3);
        for (int i = 0; i < 9; i++)
            send_op(OP_ENQ, 32'h100 + 32'(i), $urandom);
        send_op(OP_ENQ, 32'hdead_beef, 32'h7fff_ffff);
        send_op(OP_DEQ, 32'h0, 32'h0);
        drain_sender();

        random_sent = 0;
        burst_idx   = 0;
        while (random_sent < 1000)
        begin
            burst_len = $urandom_range(1, 24);
            repeat (burst_len)
            begin
                op = choose_op((burst_idx / 5) % 3);
                if (op == OP_MOD && known_values.size() > 0 && $urandom_range(0, 3) != 0)
                    value = known_values[$urandom_range(0, known_values.size() - 1)];
                else
                    value = pick_word();
                send_op(op, value, pick_word());
                random_sent++;
            end
            burst_idx++;
            if (burst_idx % 12 == 0)
                drain_sender();
            else if ($urandom_range(0, 2) != 0)
                pause_sender($urandom_range(1, 12));
        end

        drain_sender();
        repeat (150) @(negedge clk);
        $display("Covered %0d enqueue, %0d dequeue, %0d modify and %0d peek transfers; %0d results checked.",
                 op_sent[OP_ENQ], op_sent[OP_DEQ], op_sent[OP_MOD], op_sent[OP_PEEK],
                 results_checked);
        $display("Error statuses returned: %0d full, %0d empty, %0d data not found.",
                 full_hits, empty_hits, missing_hits);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Run timed out with %0d results still outstanding.", outstanding);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
